@@ rtl/ggpc_pkg.sv @@
// Shared types, constants and helper functions of the gated gait phase clock.
package ggpc_pkg;

    // Request payloads
    typedef struct packed {
        logic signed [15:0] cmd_x;
        logic signed [15:0] cmd_y;
        logic signed [15:0] cmd_yaw;
        logic        [31:0] episode_count;
    } ggpc_in_t;

    typedef struct packed {
        logic signed [15:0] phase_sin;
        logic signed [15:0] phase_cos;
    } ggpc_out_t;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [15:0] ramp_lo;
        logic [15:0] ramp_hi;
        logic [31:0] phase_step;
    } ggpc_cfg_t;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_STAND = 2'd0,
        REG_MOVE  = 2'd1,
        REG_STEP  = 2'd2
    } ggpc_reg_t;

    localparam int unsigned CFG_ADDR_W = 4;

    // Reset values
    localparam logic [15:0] STAND_RESET = 16'd0;
    localparam logic [15:0] MOVE_RESET  = 16'd4096;
    localparam logic [31:0] STEP_RESET  = 32'd85899346;

    // Fixed-point constants: one in Q2.30, pi/2 in Q2.30, quarter turn in Q0.32
    localparam logic [31:0] Q30_ONE     = 32'd1073741824;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] QUARTER     = 32'h4000_0000;

    // Pipeline depths of the two datapath units and their alignment
    localparam int unsigned GATE_LAT  = 47;
    localparam int unsigned SINE_LAT  = 19;
    localparam int unsigned H_DELAY   = 1;
    localparam int unsigned PH_DELAY  = GATE_LAT + H_DELAY - SINE_LAT - 1;
    localparam int unsigned OUT_STAGE = GATE_LAT + H_DELAY + 1;

    // Sine series: number of Horner rounds; divisors x^11 down to x^3 are
    // 110, 72, 42, 20, 6, each done as a pre-shift for the power of two and a
    // reciprocal multiply by the odd part
    localparam int unsigned SINE_ROUNDS = 5;

    function automatic int unsigned sine_pre(input int unsigned idx);
        int unsigned s;
        case (idx)
            0:       s = 1;
            1:       s = 3;
            2:       s = 1;
            3:       s = 2;
            default: s = 1;
        endcase
        return s;
    endfunction

    // ceil(2^(31+L) / odd part), exact for any dividend below 2^31
    function automatic logic [31:0] sine_recip(input int unsigned idx);
        logic [31:0] m;
        case (idx)
            0:       m = 32'd2498890064;
            1:       m = 32'd3817748708;
            2:       m = 32'd3272356036;
            3:       m = 32'd3435973837;
            default: m = 32'd2863311531;
        endcase
        return m;
    endfunction

    function automatic int unsigned sine_post(input int unsigned idx);
        int unsigned s;
        case (idx)
            0:       s = 37;
            1:       s = 35;
            2:       s = 36;
            3:       s = 34;
            default: s = 33;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/ggpc_gate.sv @@
// Gate pipeline: command magnitude, linear ramp, smoothstep shaping (Q1.16 out).
module ggpc_gate import ggpc_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] cmd_x,
    input  logic signed [15:0] cmd_y,
    input  logic signed [15:0] cmd_yaw,
    input  ggpc_cfg_t          cfg,
    output logic        [16:0] gate
);

    localparam int unsigned SQ_STEPS  = 24;
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned FL_LEN    = SQ_STEPS + DIV_STEPS + 2;

    typedef struct packed {
        logic zero;
        logic one;
    } gflag_t;

    logic [30:0] sqx_reg, sqy_reg, sqz_reg;
    logic [31:0] s2_reg;
    logic [47:0] v_reg;
    gflag_t      fl_reg [0:FL_LEN-1];
    logic [47:0] sqv_reg [0:SQ_STEPS-1];
    logic [47:0] sqr_reg [0:SQ_STEPS-1];
    logic [23:0] num_reg;
    logic [24:0] drem_reg [0:DIV_STEPS-1];
    logic [15:0] dq_reg [0:DIV_STEPS-1];
    logic [16:0] g_reg, g2_reg, gg_reg, h_reg;

    logic [31:0] st2, mv2;
    logic        unordered;
    logic [23:0] base, root;
    logic [24:0] den;

    assign st2       = 32'(cfg.ramp_lo) * 32'(cfg.ramp_lo);
    assign mv2       = 32'(cfg.ramp_hi) * 32'(cfg.ramp_hi);
    assign unordered = (cfg.ramp_hi <= cfg.ramp_lo);
    assign base      = {cfg.ramp_lo, 8'd0};
    assign den       = {1'b0, cfg.ramp_hi - cfg.ramp_lo, 8'd0};
    assign root      = sqr_reg[SQ_STEPS-1][23:0];

    // Squares, sum, then range flags
    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= 31'(32'(cmd_x) * 32'(cmd_x));
            sqy_reg <= 31'(32'(cmd_y) * 32'(cmd_y));
            sqz_reg <= 31'(32'(cmd_yaw) * 32'(cmd_yaw));
            s2_reg  <= 32'(sqx_reg) + 32'(sqy_reg) + 32'(sqz_reg);
            v_reg   <= {s2_reg, 16'd0};
            fl_reg[0].zero <= unordered ? (s2_reg <= st2) : (s2_reg <= st2);
            fl_reg[0].one  <= unordered ? (s2_reg > st2) : (s2_reg >= mv2);
        end
    end

    // Flags ride along with the data
    for (genvar k = 1; k < FL_LEN; k++) begin : g_fl
        always_ff @(posedge aclk) begin
            if (en) begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    // Square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [47:0] BIT = 48'(1) << (46 - 2 * k);
        logic [47:0] v_in, r_in;
        logic [48:0] trial;
        if (k == 0) begin : g_first
            assign v_in = v_reg;
            assign r_in = '0;
        end else begin : g_next
            assign v_in = sqv_reg[k-1];
            assign r_in = sqr_reg[k-1];
        end
        assign trial = {1'b0, r_in} + {1'b0, BIT};
        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, v_in} >= trial) begin
                    sqv_reg[k] <= 48'({1'b0, v_in} - trial);
                    sqr_reg[k] <= (r_in >> 1) + BIT;
                end else begin
                    sqv_reg[k] <= v_in;
                    sqr_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    // Ramp numerator
    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= (root > base) ? root - base : 24'd0;
        end
    end

    // Restoring divide, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [24:0] rem_in;
        logic [15:0] q_in;
        logic [25:0] sh;
        if (k == 0) begin : g_first
            assign rem_in = {1'b0, num_reg};
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = drem_reg[k-1];
            assign q_in   = dq_reg[k-1];
        end
        assign sh = {rem_in, 1'b0};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (sh >= {1'b0, den}) begin
                    drem_reg[k] <= 25'(sh - {1'b0, den});
                    dq_reg[k]   <= {q_in[14:0], 1'b1};
                end else begin
                    drem_reg[k] <= sh[24:0];
                    dq_reg[k]   <= {q_in[14:0], 1'b0};
                end
            end
        end
    end

    // Gate select, then smoothstep g*g*(3-2g)
    always_ff @(posedge aclk) begin
        if (en) begin
            if (fl_reg[FL_LEN-1].zero) begin
                g_reg <= 17'd0;
            end else if (fl_reg[FL_LEN-1].one) begin
                g_reg <= 17'd65536;
            end else begin
                g_reg <= {1'b0, dq_reg[DIV_STEPS-1]};
            end
            gg_reg <= 17'((34'(g_reg) * 34'(g_reg)) >> 16);
            g2_reg <= g_reg;
            h_reg  <= 17'((35'(gg_reg) * (35'(196608) - 35'({g2_reg, 1'b0}))) >> 16);
        end
    end

    assign gate = h_reg;

endmodule

@@ rtl/ggpc_sine.sv @@
// Sine of a Q0.32 turn: Q1.30 magnitude and sign, Taylor series by Horner.
module ggpc_sine import ggpc_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] turn,
    output logic [30:0] mag,
    output logic        neg
);

    // Each round: product, reciprocal divide, subtract from one
    localparam int unsigned RND_LAT  = 3;
    localparam int unsigned SIDE_LEN = SINE_ROUNDS * RND_LAT + 1;

    typedef struct packed {
        logic        neg;
        logic [30:0] x;
        logic [31:0] x2;
    } side_t;

    logic [30:0] r_reg, x_reg, mag_reg;
    logic        neg1_reg, neg2_reg, neg_reg;
    side_t       sd_reg [0:SIDE_LEN-1];
    logic [31:0] a_reg [0:SINE_ROUNDS-1];
    logic [31:0] q_reg [0:SINE_ROUNDS-1];
    logic [30:0] p_reg [0:SINE_ROUNDS-1];

    // Quadrant fold, angle in radians, angle squared
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= turn[30] ? 31'(Q30_ONE - {2'b00, turn[29:0]}) : {1'b0, turn[29:0]};
            neg1_reg <= turn[31];
            x_reg    <= 31'((62'(r_reg) * 62'(HALF_PI_Q30)) >> 30);
            neg2_reg <= neg1_reg;
            sd_reg[0].neg <= neg2_reg;
            sd_reg[0].x   <= x_reg;
            sd_reg[0].x2  <= 32'((62'(x_reg) * 62'(x_reg)) >> 30);
        end
    end

    for (genvar k = 1; k < SIDE_LEN; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // Horner rounds: p = 1 - (x2*p)/d
    for (genvar r = 0; r < SINE_ROUNDS; r++) begin : g_rnd
        localparam int unsigned PRE   = sine_pre(r);
        localparam int unsigned POST  = sine_post(r);
        localparam logic [31:0] RECIP = sine_recip(r);
        logic [30:0] p_in;
        if (r == 0) begin : g_first
            assign p_in = Q30_ONE[30:0];
        end else begin : g_next
            assign p_in = p_reg[r-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[r] <= 32'((63'(sd_reg[r*RND_LAT].x2) * 63'(p_in)) >> 30);
                q_reg[r] <= 32'((63'(a_reg[r] >> PRE) * 63'(RECIP)) >> POST);
                if (q_reg[r] >= Q30_ONE) begin
                    p_reg[r] <= 31'd0;
                end else begin
                    p_reg[r] <= 31'(Q30_ONE - q_reg[r]);
                end
            end
        end
    end

    // Final multiply by x
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= 31'((62'(sd_reg[SIDE_LEN-1].x) * 62'(p_reg[SINE_ROUNDS-1])) >> 30);
            neg_reg <= sd_reg[SIDE_LEN-1].neg;
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

@@ rtl/gated_gait_phase_clock.sv @@
// Top level of the gated gait phase clock: config port, phase, pipeline control.
// Throughput: one request per cycle; the pipeline is one shift chain that holds
// as a whole while a result waits on m_ready (s_ready = !m_valid || m_ready).
// Depth is set by the gate: bit-per-stage square root and ramp divide; the phase
// is delayed so the sine units finish with it. Reset (aresetn low, synchronous)
// empties the pipeline and restores the registers.
module gated_gait_phase_clock import ggpc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ggpc_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ggpc_out_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    ggpc_cfg_t   cfg_reg;
    ggpc_in_t    in_reg;
    logic [31:0] phase_reg;
    logic [31:0] ph_dly_reg [0:PH_DELAY-1];
    logic        vld_reg [0:OUT_STAGE];
    logic [16:0] h_dly_reg [0:H_DELAY-1];
    ggpc_out_t   out_reg;
    logic        en;
    logic [16:0] gate;
    logic [30:0] sin_mag, cos_mag;
    logic        sin_neg, cos_neg;
    ggpc_reg_t   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = ggpc_reg_t'(paddr[3:2]);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_lo    <= STAND_RESET;
            cfg_reg.ramp_hi    <= MOVE_RESET;
            cfg_reg.phase_step <= STEP_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_STAND: cfg_reg.ramp_lo    <= pwdata[15:0];
                REG_MOVE:  cfg_reg.ramp_hi    <= pwdata[15:0];
                REG_STEP:  cfg_reg.phase_step <= pwdata;
                default:   ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_STAND: prdata = {16'd0, cfg_reg.ramp_lo};
            REG_MOVE:  prdata = {16'd0, cfg_reg.ramp_hi};
            REG_STEP:  prdata = cfg_reg.phase_step;
            default:   prdata = 32'd0;
        endcase
    end

    // Whole pipeline advances unless a result is held
    assign en      = !vld_reg[OUT_STAGE] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[OUT_STAGE];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
        end
    end

    for (genvar k = 1; k <= OUT_STAGE; k++) begin : g_vld
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Input capture and phase = count * step, low 32 bits
    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg    <= s_data;
            phase_reg <= 32'(64'(in_reg.episode_count) * 64'(cfg_reg.phase_step));
        end
    end

    // Hold the phase back so the sine units line up with the gate
    for (genvar k = 0; k < PH_DELAY; k++) begin : g_phdly
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) begin
                    ph_dly_reg[k] <= phase_reg;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en) begin
                    ph_dly_reg[k] <= ph_dly_reg[k-1];
                end
            end
        end
    end

    ggpc_gate u_gate (
        .aclk    (aclk),
        .en      (en),
        .cmd_x   (in_reg.cmd_x),
        .cmd_y   (in_reg.cmd_y),
        .cmd_yaw (in_reg.cmd_yaw),
        .cfg     (cfg_reg),
        .gate    (gate)
    );

    ggpc_sine u_sin (
        .aclk (aclk),
        .en   (en),
        .turn (ph_dly_reg[PH_DELAY-1]),
        .mag  (sin_mag),
        .neg  (sin_neg)
    );

    ggpc_sine u_cos (
        .aclk (aclk),
        .en   (en),
        .turn (ph_dly_reg[PH_DELAY-1] + QUARTER),
        .mag  (cos_mag),
        .neg  (cos_neg)
    );

    // Align the gate with the sine outputs
    for (genvar k = 0; k < H_DELAY; k++) begin : g_hdly
        always_ff @(posedge aclk) begin
            if (en) begin
                h_dly_reg[k] <= (k == 0) ? gate : h_dly_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Gate times sine, round half up, saturate to Q1.15
    function automatic logic [15:0] gated(input logic [30:0] s, input logic neg_in,
                                          input logic [16:0] h);
        logic [48:0] prod;
        logic [17:0] m;
        logic [15:0] res;
        prod = 49'(s) * 49'(h) + 49'(Q30_ONE);
        m    = prod[48:31];
        if (neg_in) begin
            res = (m > 18'd32768) ? 16'h8000 : 16'(18'd0 - m);
        end else begin
            res = (m > 18'd32767) ? 16'h7FFF : m[15:0];
        end
        return res;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.phase_sin <= gated(sin_mag, sin_neg, h_dly_reg[H_DELAY-1]);
            out_reg.phase_cos <= gated(cos_mag, cos_neg, h_dly_reg[H_DELAY-1]);
        end
    end

endmodule

@@ rtl/ggpc_checker.sv @@
// Port-level checks for the gated gait phase clock, bound to the top level.
module ggpc_checker import ggpc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input ggpc_out_t m_data,
    input logic      pready
);

    // A held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Requests are refused exactly while a result is held
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Config port never waits
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind gated_gait_phase_clock ggpc_checker u_ggpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

@@ verif/tb_gated_gait_phase_clock.sv @@
// Testbench of the gated gait phase clock: directed and random requests against a local predictor.
`timescale 1ns / 1ps

module tb_gated_gait_phase_clock;
    import ggpc_pkg::*;

    localparam int unsigned LATENCY    = 49;
    localparam int unsigned IDLE_LIMIT = 20000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    ggpc_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    ggpc_out_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Local copy of the registers
    logic [15:0] stand_q;
    logic [15:0] move_q;
    logic [31:0] step_q;

    ggpc_out_t clock_expected[$];
    int        mismatches;
    int        idle_cycles;
    bit        hold_rx;
    bit        rx_fast;

    gated_gait_phase_clock DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Integer square root, bitwise
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Gated sine of a Q0.32 turn, Q1.15 output
    function automatic logic [15:0] gated_sine(input logic [31:0] t, input logic [63:0] h);
        logic [63:0] r, x, x2, p, term, s, m;
        logic        neg;
        logic [63:0] divs[5];
        divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        r = {34'd0, t[29:0]};
        if (t[30]) r = 64'd1073741824 - r;
        neg = t[31];
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        p = 64'd1073741824;
        for (int i = 0; i < 5; i++) begin
            term = ((x2 * p) >> 30) / divs[i];
            p = (term >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - term;
        end
        s = (x * p) >> 30;
        m = (s * h + (64'd1 << 30)) >> 31;
        if (neg) begin
            if (m > 32768) m = 32768;
            return 16'(17'h10000 - m[16:0]);
        end
        if (m > 32767) m = 32767;
        return m[15:0];
    endfunction

    function automatic ggpc_out_t predict_clock(input ggpc_in_t req);
        logic signed [63:0] cx, cy, cz;
        logic [63:0] s2, st2, mv2, g, h, n, base, den, num;
        logic [31:0] ph;
        ggpc_out_t r;
        cx = req.cmd_x;
        cy = req.cmd_y;
        cz = req.cmd_yaw;
        s2 = cx * cx + cy * cy + cz * cz;
        st2 = 64'(stand_q) * 64'(stand_q);
        mv2 = 64'(move_q) * 64'(move_q);
        if (move_q <= stand_q) g = (s2 > st2) ? 64'd65536 : 64'd0;
        else if (s2 <= st2) g = 0;
        else if (s2 >= mv2) g = 65536;
        else begin
            n = int_sqrt(s2 << 16);
            base = 64'(stand_q) << 8;
            den = 64'(move_q - stand_q) << 8;
            num = (n > base) ? n - base : 64'd0;
            g = (num << 16) / den;
            if (g > 65536) g = 65536;
        end
        h = (((g * g) >> 16) * (64'd196608 - 2 * g)) >> 16;
        ph = req.episode_count * step_q;
        r.phase_sin = gated_sine(ph, h);
        r.phase_cos = gated_sine(ph + QUARTER, h);
        return r;
    endfunction

    // Register write, setup then access
    task automatic write_reg(input ggpc_reg_t idx, input logic [31:0] val);
        @(negedge aclk);
        psel = 1; penable = 0; pwrite = 1; paddr = CFG_ADDR_W'(idx) << 2; pwdata = val;
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            REG_STAND: stand_q = val[15:0];
            REG_MOVE:  move_q = val[15:0];
            default:   step_q = val;
        endcase
    endtask

    task automatic set_config(input logic [15:0] st, input logic [15:0] mv,
                              input logic [31:0] stp);
        wait (clock_expected.size() == 0);
        repeat (LATENCY + 4) @(negedge aclk);
        write_reg(REG_STAND, {16'd0, st});
        write_reg(REG_MOVE, {16'd0, mv});
        write_reg(REG_STEP, stp);
    endtask

    // One request; gap drawn before it, mostly short
    task automatic send_cmd(input ggpc_in_t req, input bit gaps);
        int g;
        if (gaps) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            repeat (g) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        clock_expected.push_back(predict_clock(req));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [15:0] rand_cmd();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic ggpc_in_t rand_req();
        ggpc_in_t r;
        r.cmd_x = rand_cmd();
        r.cmd_y = ($urandom_range(0, 2) == 0) ? 16'd0 : rand_cmd();
        r.cmd_yaw = ($urandom_range(0, 2) == 0) ? 16'd0 : rand_cmd();
        r.episode_count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000) : $urandom();
        return r;
    endfunction

    task automatic test_directed();
        ggpc_in_t r;
        logic [15:0] ext[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        for (int i = 0; i < 4; i++) begin
            r = '{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 32'hFFFF_FFFF};
            send_cmd(r, 0);
        end
        // Exactly on and around the thresholds, quadrant boundaries of the phase
        send_cmd('{16'd0, 16'd0, 16'd0, 32'd0}, 0);
        send_cmd('{16'd4096, 16'd0, 16'd0, 32'd0}, 0);
        send_cmd('{16'd2048, 16'd0, 16'd0, 32'd25}, 0);
        send_cmd('{16'd1, 16'd0, 16'd0, 32'd50}, 0);
        send_cmd('{16'd4095, 16'd0, 16'd0, 32'd75}, 0);
        send_cmd('{-16'sd3000, 16'd2000, 16'd1000, 32'd100}, 0);
    endtask

    task automatic test_config_sweep();
        set_config(16'd1000, 16'd1000, 32'h4000_0000);   // equal thresholds
        send_cmd('{16'd1000, 16'd0, 16'd0, 32'd1}, 0);
        send_cmd('{16'd1001, 16'd0, 16'd0, 32'd2}, 0);
        set_config(16'd8000, 16'd100, 32'hFFFF_FFFF);    // reversed thresholds
        send_cmd('{16'd8001, 16'd0, 16'd0, 32'd3}, 0);
        send_cmd('{16'd100, 16'd0, 16'd0, 32'hFFFF_FFFF}, 0);
        set_config(16'hFFFF, 16'hFFFF, 32'd0);
        send_cmd('{16'h8000, 16'h8000, 16'h8000, 32'd7}, 0);
        set_config(16'd0, 16'hFFFF, 32'h8000_0001);
        send_cmd('{16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd5}, 0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_cmd(rand_req(), 1);
    endtask

    task automatic test_backpressure();
        set_config(16'd500, 16'd6000, 32'd85899346);
        hold_rx = 1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_rx = 0;
            end
            for (int i = 0; i < 120; i++) send_cmd(rand_req(), 0);
        join
    endtask

    // Receiver stalls
    always @(negedge aclk) begin
        if (!aresetn || hold_rx) m_ready <= 1'b0;
        else if (rx_fast) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 40) == 0);
    end

    always @(negedge aclk) begin
        if ($urandom_range(0, 300) == 0) rx_fast <= ~rx_fast;
    end

    // Result checker
    always @(posedge aclk) begin
        ggpc_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (clock_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                e = clock_expected.pop_front();
                if (e.phase_sin !== m_data.phase_sin || e.phase_cos !== m_data.phase_cos) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected sin %0d cos %0d, got sin %0d cos %0d",
                                 e.phase_sin, e.phase_cos, m_data.phase_sin, m_data.phase_cos);
                end
            end
        end
    end

    // Watchdog on acceptance activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        hold_rx = 0;
        rx_fast = 0;
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        stand_q = STAND_RESET;
        move_q = MOVE_RESET;
        step_q = STEP_RESET;
        repeat (12) @(negedge aclk);
        aresetn = 1;

        test_directed();
        test_config_sweep();
        test_backpressure();
        set_config(16'd0, 16'd4096, STEP_RESET);
        test_random(700);
        set_config(16'd2000, 16'd12000, 32'd12345677);
        test_random(700);
        set_config(16'd0, 16'd0, $urandom());
        test_random(300);
        set_config(16'd3000, 16'd3500, 32'h0100_0000);
        test_random(300);

        wait (clock_expected.size() == 0);
        repeat (LATENCY + 10) @(negedge aclk);
        if (mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
